// File: sv/co2rx_pkg.sv
// shared types, widths and codes for the co2 sensor response receiver
package co2rx_pkg;

    localparam int BYTE_W     = 8;
    localparam int PPM_W      = 16;
    localparam int TEMP_W     = 19;
    localparam int TICK_W     = 32;
    localparam int WAIT_W     = 17;
    localparam int TIMEOUT_W  = 16;
    localparam int COUNT_W    = 4;

    localparam int FRAME_BYTES       = 9;
    localparam int QUEUE_DEPTH_DEF   = 2;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [WAIT_W-1:0]    WAIT_MAX      = 17'h1FFFF;

    // temperature offset and scale
    localparam logic signed [9:0]        TEMP_OFFSET = 10'sd40;
    localparam logic signed [TEMP_W-1:0] TEMP_SCALE  = 19'sd1000;

    // frame byte positions
    localparam logic [COUNT_W-1:0] POS_START   = 4'd0;
    localparam logic [COUNT_W-1:0] POS_CO2_HI  = 4'd2;
    localparam logic [COUNT_W-1:0] POS_CO2_LO  = 4'd3;
    localparam logic [COUNT_W-1:0] POS_TEMP    = 4'd4;
    localparam logic [COUNT_W-1:0] POS_ACC     = 4'd5;
    localparam logic [COUNT_W-1:0] POS_MIN_HI  = 4'd6;
    localparam logic [COUNT_W-1:0] POS_MIN_LO  = 4'd7;
    localparam logic [COUNT_W-1:0] POS_CHECK   = 4'd8;

    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_REQUEST = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC     = 2'd1,
        ST_TIMEOUT = 2'd2
    } status_t;

    // one classified event handed from front to back
    typedef struct packed {
        status_t             status;
        logic [PPM_W-1:0]    co2;
        logic [BYTE_W-1:0]   temp_raw;
        logic [BYTE_W-1:0]   accuracy;
        logic [PPM_W-1:0]    min_co2;
        logic [TICK_W-1:0]   stamp;
    } job_t;

endpackage

// File: sv/co2rx_front.sv
// front end: request tracking, tick counting, frame capture and checksum
module co2rx_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_action,
    input  logic [co2rx_pkg::BYTE_W-1:0]      s_rx_byte,
    input  logic                              cfg_wr_en,
    input  logic [co2rx_pkg::TIMEOUT_W-1:0]   cfg_wr_data,
    output logic                              job_valid,
    output co2rx_pkg::job_t                   job,
    input  logic                              job_ready
);
    import co2rx_pkg::*;

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic                 pending_reg, pending_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [WAIT_W-1:0]    wait_reg, wait_next;
    logic [TICK_W-1:0]    now_reg, now_next;
    logic [BYTE_W-1:0]    sum_reg, sum_next;
    logic [BYTE_W-1:0]    co2_hi_reg, co2_lo_reg, temp_reg, acc_reg, min_hi_reg, min_lo_reg;
    logic [WAIT_W-1:0]    wait_inc;
    logic                 accept;
    action_t              act;

    assign s_ready = job_ready;
    assign accept  = s_valid && s_ready;
    assign act     = action_t'(s_action);
    assign wait_inc = (wait_reg < WAIT_MAX) ? wait_reg + 1'b1 : wait_reg;

    always_comb begin
        pending_next = pending_reg;
        count_next   = count_reg;
        wait_next    = wait_reg;
        now_next     = now_reg;
        sum_next     = sum_reg;
        job_valid    = 1'b0;
        job.status   = ST_OK;
        job.co2      = {co2_hi_reg, co2_lo_reg};
        job.temp_raw = temp_reg;
        job.accuracy = acc_reg;
        job.min_co2  = {min_hi_reg, min_lo_reg};
        job.stamp    = now_reg;
        if (accept) begin
            case (act)
                ACT_REQUEST: begin
                    pending_next = 1'b1;
                    count_next   = '0;
                    wait_next    = '0;
                end
                ACT_TICK: begin
                    now_next = now_reg + 1'b1;
                    if (pending_reg) begin
                        if (timeout_reg != '0 && wait_inc > {1'b0, timeout_reg}) begin
                            pending_next = 1'b0;
                            count_next   = '0;
                            wait_next    = '0;
                            job_valid    = 1'b1;
                            job.status   = ST_TIMEOUT;
                        end else begin
                            wait_next = wait_inc;
                        end
                    end
                end
                ACT_BYTE: begin
                    if (pending_reg) begin
                        if (count_reg == POS_START) begin
                            sum_next = '0;
                        end else begin
                            sum_next = sum_reg + s_rx_byte;
                        end
                        if (count_reg == POS_CHECK) begin
                            // sum of bytes 1..8 is zero mod 256 when the check byte matches
                            pending_next = 1'b0;
                            count_next   = '0;
                            wait_next    = '0;
                            job_valid    = 1'b1;
                            job.status   = (sum_next == '0) ? ST_OK : ST_CRC;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            pending_reg <= 1'b0;
            count_reg   <= '0;
            wait_reg    <= '0;
            now_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            pending_reg <= pending_next;
            count_reg   <= count_next;
            wait_reg    <= wait_next;
            now_reg     <= now_next;
        end
    end

    // captured frame fields, no reset needed
    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        if (accept && act == ACT_BYTE && pending_reg) begin
            case (count_reg)
                POS_CO2_HI: co2_hi_reg <= s_rx_byte;
                POS_CO2_LO: co2_lo_reg <= s_rx_byte;
                POS_TEMP:   temp_reg   <= s_rx_byte;
                POS_ACC:    acc_reg    <= s_rx_byte;
                POS_MIN_HI: min_hi_reg <= s_rx_byte;
                POS_MIN_LO: min_lo_reg <= s_rx_byte;
                default: begin
                end
            endcase
        end
    end

endmodule

// File: sv/co2rx_queue.sv
// small fifo between front and back
module co2rx_queue #(
    parameter int DEPTH = co2rx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  co2rx_pkg::job_t   push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output co2rx_pkg::job_t   pop_data
);
    import co2rx_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// File: sv/co2rx_back.sv
// back end: measurement registers, running maximum and result register
module co2rx_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  co2rx_pkg::job_t               job,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [co2rx_pkg::PPM_W-1:0]   m_co2_ppm,
    output logic signed [co2rx_pkg::TEMP_W-1:0] m_temp_milli_c,
    output logic [co2rx_pkg::BYTE_W-1:0]  m_accuracy_byte,
    output logic [co2rx_pkg::PPM_W-1:0]   m_min_co2_ppm,
    output logic [co2rx_pkg::PPM_W-1:0]   m_max_co2_ppm,
    output logic [co2rx_pkg::TICK_W-1:0]  m_measure_time
);
    import co2rx_pkg::*;

    logic                     valid_reg;
    status_t                  status_reg;
    logic [PPM_W-1:0]         co2_reg, min_reg, max_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic [BYTE_W-1:0]        acc_reg;
    logic [TICK_W-1:0]        time_reg;
    logic signed [9:0]        temp_off;
    logic signed [TEMP_W-1:0] temp_next;
    logic                     take;

    // state registers double as the result register: they change only on a new request out
    assign job_ready = !valid_reg || m_ready;
    assign take      = job_valid && job_ready;
    assign temp_off  = $signed({2'b00, job.temp_raw}) - TEMP_OFFSET;
    assign temp_next = TEMP_W'(temp_off) * TEMP_SCALE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            status_reg <= ST_OK;
            co2_reg    <= '0;
            temp_reg   <= '0;
            acc_reg    <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
            time_reg   <= '0;
        end else begin
            if (take) begin
                valid_reg  <= 1'b1;
                status_reg <= job.status;
                if (job.status != ST_TIMEOUT) begin
                    co2_reg  <= job.co2;
                    temp_reg <= temp_next;
                    acc_reg  <= job.accuracy;
                    min_reg  <= job.min_co2;
                    if (job.co2 > max_reg) begin
                        max_reg <= job.co2;
                    end
                    if (job.status == ST_OK) begin
                        time_reg <= job.stamp;
                    end
                end
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = valid_reg;
    assign m_status        = status_reg;
    assign m_co2_ppm       = co2_reg;
    assign m_temp_milli_c  = temp_reg;
    assign m_accuracy_byte = acc_reg;
    assign m_min_co2_ppm   = min_reg;
    assign m_max_co2_ppm   = max_reg;
    assign m_measure_time  = time_reg;

endmodule

// File: sv/co2_sensor_response_receiver_unit.sv
// top level of the co2 sensor response receiver
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  s_       | s_valid / s_ready  | s_action, s_rx_byte
//  m_       | m_valid / m_ready  | m_status, m_co2_ppm, m_temp_milli_c, ...
//  cfg_     | cfg_wr_en          | cfg_wr_data (timeout in ticks)
//
// one event is taken per cycle while s_ready is high; the event completing a result
// passes through a queue entry, then the result register, before m_valid rises.
// s_ready follows the queue fill only; with m_ready low the result register and
// QUEUE_DEPTH queue entries fill before the input stalls.
// reset is synchronous and clears counters, request state and measurements.
module co2_sensor_response_receiver_unit #(
    parameter int QUEUE_DEPTH = co2rx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_action,
    input  logic [co2rx_pkg::BYTE_W-1:0]         s_rx_byte,
    input  logic                                 cfg_wr_en,
    input  logic [co2rx_pkg::TIMEOUT_W-1:0]      cfg_wr_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_status,
    output logic [co2rx_pkg::PPM_W-1:0]          m_co2_ppm,
    output logic signed [co2rx_pkg::TEMP_W-1:0]  m_temp_milli_c,
    output logic [co2rx_pkg::BYTE_W-1:0]         m_accuracy_byte,
    output logic [co2rx_pkg::PPM_W-1:0]          m_min_co2_ppm,
    output logic [co2rx_pkg::PPM_W-1:0]          m_max_co2_ppm,
    output logic [co2rx_pkg::TICK_W-1:0]         m_measure_time
);
    import co2rx_pkg::*;

    logic push_valid, push_ready, pop_valid, pop_ready;
    job_t push_data, pop_data;

    co2rx_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_rx_byte   (s_rx_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .job_valid   (push_valid),
        .job         (push_data),
        .job_ready   (push_ready)
    );

    co2rx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    co2rx_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .job_valid       (pop_valid),
        .job_ready       (pop_ready),
        .job             (pop_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_co2_ppm       (m_co2_ppm),
        .m_temp_milli_c  (m_temp_milli_c),
        .m_accuracy_byte (m_accuracy_byte),
        .m_min_co2_ppm   (m_min_co2_ppm),
        .m_max_co2_ppm   (m_max_co2_ppm),
        .m_measure_time  (m_measure_time)
    );

endmodule

// File: bench/co2rx_checker.sv
// checker for the co2 sensor response receiver: predicts readings and compares results
module co2rx_checker
    import co2rx_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [1:0]                  s_action,
    input  logic [BYTE_W-1:0]           s_rx_byte,
    input  logic                        cfg_wr_en,
    input  logic [TIMEOUT_W-1:0]        cfg_wr_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [1:0]                  m_status,
    input  logic [PPM_W-1:0]            m_co2_ppm,
    input  logic signed [TEMP_W-1:0]    m_temp_milli_c,
    input  logic [BYTE_W-1:0]           m_accuracy_byte,
    input  logic [PPM_W-1:0]            m_min_co2_ppm,
    input  logic [PPM_W-1:0]            m_max_co2_ppm,
    input  logic [TICK_W-1:0]           m_measure_time,
    output int                          fail_count,
    output int                          readings_due,
    output int                          readings_seen,
    output int                          timeouts_seen,
    output int                          crc_errors_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t                    status;
        logic [PPM_W-1:0]           co2;
        logic signed [TEMP_W-1:0]   temp;
        logic [BYTE_W-1:0]          accuracy;
        logic [PPM_W-1:0]           min_co2;
        logic [PPM_W-1:0]           max_co2;
        logic [TICK_W-1:0]          stamp;
    } reading_t;

    logic [TIMEOUT_W-1:0]       timeout_ticks;
    logic [BYTE_W-1:0]          frame [FRAME_BYTES];
    logic [COUNT_W-1:0]         bytes_held;
    logic                       awaiting;
    logic [WAIT_W-1:0]          waited;
    logic [TICK_W-1:0]          tick_now;
    logic [PPM_W-1:0]           co2_last;
    logic signed [TEMP_W-1:0]   temp_last;
    logic [BYTE_W-1:0]          acc_last;
    logic [PPM_W-1:0]           min_last;
    logic [PPM_W-1:0]           co2_peak;
    logic [TICK_W-1:0]          stamp_last;

    reading_t   readings_q [$];
    reading_t   oldest;
    int         fails = 0;
    int         seen = 0;
    int         tmo = 0;
    int         crc = 0;

    function automatic reading_t snapshot(input status_t st);
        reading_t r;
        r.status   = st;
        r.co2      = co2_last;
        r.temp     = temp_last;
        r.accuracy = acc_last;
        r.min_co2  = min_last;
        r.max_co2  = co2_peak;
        r.stamp    = stamp_last;
        return r;
    endfunction

    task automatic take_event(input logic [1:0] act, input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] check;
        int t;
        case (act)
            ACT_REQUEST: begin
                // a new request restarts collection and the wait
                awaiting   = 1'b1;
                bytes_held = '0;
                waited     = '0;
            end
            ACT_TICK: begin
                tick_now = tick_now + 1'b1;
                if (awaiting) begin
                    if (waited != WAIT_MAX) waited = waited + 1'b1;
                    if (timeout_ticks != '0 && waited > timeout_ticks) begin
                        awaiting   = 1'b0;
                        bytes_held = '0;
                        waited     = '0;
                        readings_q.push_back(snapshot(ST_TIMEOUT));
                    end
                end
            end
            ACT_BYTE: begin
                if (awaiting) begin
                    if (bytes_held >= FRAME_BYTES) bytes_held = '0;
                    frame[bytes_held] = b;
                    bytes_held = bytes_held + 1'b1;
                    if (bytes_held == FRAME_BYTES) begin
                        sum = '0;
                        for (int i = 1; i < 8; i++) sum = sum + frame[i];
                        check = 8'd0 - sum;
                        co2_last  = {frame[POS_CO2_HI], frame[POS_CO2_LO]};
                        t = (int'(frame[POS_TEMP]) - 40) * 1000;
                        temp_last = t[TEMP_W-1:0];
                        acc_last  = frame[POS_ACC];
                        min_last  = {frame[POS_MIN_HI], frame[POS_MIN_LO]};
                        if (co2_last > co2_peak) co2_peak = co2_last;
                        // bad checksum still updates the values, only the stamp waits
                        if (frame[POS_CHECK] == check) stamp_last = tick_now;
                        awaiting   = 1'b0;
                        bytes_held = '0;
                        waited     = '0;
                        readings_q.push_back(
                            snapshot(frame[POS_CHECK] == check ? ST_OK : ST_CRC));
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ticks = TIMEOUT_RESET;
            bytes_held    = '0;
            awaiting      = 1'b0;
            waited        = '0;
            tick_now      = '0;
            co2_last      = '0;
            temp_last     = '0;
            acc_last      = '0;
            min_last      = '0;
            co2_peak      = '0;
            stamp_last    = '0;
            readings_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen++;
                if (m_status == ST_TIMEOUT) tmo++;
                if (m_status == ST_CRC) crc++;
                if (readings_q.size() == 0) begin
                    $error("result with no reading due, status %0d co2 %0d",
                           m_status, m_co2_ppm);
                    fails++;
                end else begin
                    oldest = readings_q.pop_front();
                    if (m_status != oldest.status) begin
                        $error("status expected %0d actual %0d", oldest.status, m_status);
                        fails++;
                    end
                    if (m_co2_ppm != oldest.co2) begin
                        $error("co2_ppm expected %0d actual %0d", oldest.co2, m_co2_ppm);
                        fails++;
                    end
                    if (m_temp_milli_c != oldest.temp) begin
                        $error("temp_milli_c expected %0d actual %0d",
                               oldest.temp, m_temp_milli_c);
                        fails++;
                    end
                    if (m_accuracy_byte != oldest.accuracy) begin
                        $error("accuracy_byte expected %0d actual %0d",
                               oldest.accuracy, m_accuracy_byte);
                        fails++;
                    end
                    if (m_min_co2_ppm != oldest.min_co2) begin
                        $error("min_co2_ppm expected %0d actual %0d",
                               oldest.min_co2, m_min_co2_ppm);
                        fails++;
                    end
                    if (m_max_co2_ppm != oldest.max_co2) begin
                        $error("max_co2_ppm expected %0d actual %0d",
                               oldest.max_co2, m_max_co2_ppm);
                        fails++;
                    end
                    if (m_measure_time != oldest.stamp) begin
                        $error("measure_time expected %0d actual %0d",
                               oldest.stamp, m_measure_time);
                        fails++;
                    end
                end
            end
            // an event in the same cycle as a write still sees the old timeout
            if (s_valid && s_ready) take_event(s_action, s_rx_byte);
            if (cfg_wr_en) timeout_ticks = cfg_wr_data;
        end
        fail_count      <= fails;
        readings_due    <= readings_q.size();
        readings_seen   <= seen;
        timeouts_seen   <= tmo;
        crc_errors_seen <= crc;
    end

endmodule

// File: bench/tb.sv
// testbench top for the co2 sensor response receiver: stimulus, idling and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import co2rx_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 200;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_action = ACT_BYTE;
    logic [BYTE_W-1:0]          s_rx_byte = '0;
    logic                       cfg_wr_en = 1'b0;
    logic [TIMEOUT_W-1:0]       cfg_wr_data = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [1:0]                 m_status;
    logic [PPM_W-1:0]           m_co2_ppm;
    logic signed [TEMP_W-1:0]   m_temp_milli_c;
    logic [BYTE_W-1:0]          m_accuracy_byte;
    logic [PPM_W-1:0]           m_min_co2_ppm;
    logic [PPM_W-1:0]           m_max_co2_ppm;
    logic [TICK_W-1:0]          m_measure_time;

    int fail_count;
    int readings_due;
    int readings_seen;
    int timeouts_seen;
    int crc_errors_seen;

    int send_idle = 0;
    int recv_idle = 0;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;
    int hold_left = 0;
    int idle_cycles = 0;
    int events_sent = 0;
    int useful_sent = 0;
    logic [BYTE_W-1:0] probe_frame [FRAME_BYTES];

    co2_sensor_response_receiver_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_rx_byte       (s_rx_byte),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_co2_ppm       (m_co2_ppm),
        .m_temp_milli_c  (m_temp_milli_c),
        .m_accuracy_byte (m_accuracy_byte),
        .m_min_co2_ppm   (m_min_co2_ppm),
        .m_max_co2_ppm   (m_max_co2_ppm),
        .m_measure_time  (m_measure_time)
    );

    co2rx_checker score (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_rx_byte       (s_rx_byte),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_co2_ppm       (m_co2_ppm),
        .m_temp_milli_c  (m_temp_milli_c),
        .m_accuracy_byte (m_accuracy_byte),
        .m_min_co2_ppm   (m_min_co2_ppm),
        .m_max_co2_ppm   (m_max_co2_ppm),
        .m_measure_time  (m_measure_time),
        .fail_count      (fail_count),
        .readings_due    (readings_due),
        .readings_seen   (readings_seen),
        .timeouts_seen   (timeouts_seen),
        .crc_errors_seen (crc_errors_seen)
    );

    always #10 aclk = ~aclk;

    // receiver side: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_event(input logic [1:0] act, input logic [BYTE_W-1:0] b,
                              input bit counts);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_action  <= act;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        events_sent++;
        if (counts) useful_sent++;
    endtask

    function automatic logic [BYTE_W-1:0] frame_check_byte(
            input logic [BYTE_W-1:0] pkt [FRAME_BYTES]);
        logic [BYTE_W-1:0] sum;
        sum = '0;
        for (int i = 1; i < 8; i++) sum = sum + pkt[i];
        return 8'd0 - sum;
    endfunction

    // request, then the first n bytes of pkt, with stray ticks if asked
    task automatic send_packet(input logic [BYTE_W-1:0] pkt [FRAME_BYTES], input int n,
                               input bit ticks);
        send_event(ACT_REQUEST, BYTE_W'($urandom_range(255)), 1'b1);
        for (int i = 0; i < n; i++) begin
            if (ticks && $urandom_range(7) == 0)
                send_event(ACT_TICK, BYTE_W'($urandom_range(255)), 1'b1);
            if (ticks && $urandom_range(31) == 0)
                repeat ($urandom_range(30, 2))
                    send_event(ACT_TICK, BYTE_W'($urandom_range(255)), 1'b1);
            send_event(ACT_BYTE, pkt[i], 1'b1);
        end
    endtask

    task automatic send_random_frame(input int n, input bit ticks);
        logic [BYTE_W-1:0] pkt [FRAME_BYTES];
        foreach (pkt[i]) pkt[i] = BYTE_W'($urandom_range(255));
        if ($urandom_range(1)) pkt[FRAME_BYTES-1] = frame_check_byte(pkt);
        send_packet(pkt, n, ticks);
    endtask

    task automatic random_run(input int n);
        int start;
        int r;
        start = useful_sent;
        while (useful_sent - start < n) begin
            r = $urandom_range(99);
            if (r < 70) send_random_frame(FRAME_BYTES, 1'b1);
            else if (r < 80) send_random_frame($urandom_range(8, 1), 1'b1);
            else if (r < 88)
                repeat ($urandom_range(4, 1))
                    send_event(ACT_TICK, BYTE_W'($urandom_range(255)), 1'b1);
            else if (r < 94)
                repeat ($urandom_range(3, 1))
                    send_event(ACT_BYTE, BYTE_W'($urandom_range(255)), 1'b0);
            else send_event(ACT_UNUSED, BYTE_W'($urandom_range(255)), 1'b0);
        end
    endtask

    // wait for every reading to come out, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (readings_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn   <= 1'b1;
        send_idle = 32;
        recv_idle <= 86;

        // events before any request: no result, a tick only advances the time
        send_event(ACT_BYTE, 8'h00, 1'b1);
        send_event(ACT_TICK, 8'hFF, 1'b1);
        send_event(ACT_UNUSED, 8'hFF, 1'b0);

        // all-ones frame but for byte 1 (86 hex) and the check byte, with a good checksum
        foreach (probe_frame[i]) probe_frame[i] = 8'hFF;
        probe_frame[1] = 8'h86;
        probe_frame[FRAME_BYTES-1] = frame_check_byte(probe_frame);
        send_packet(probe_frame, FRAME_BYTES, 1'b0);

        // request restarts a partial frame; all-zero frame with check byte 01, bad checksum
        foreach (probe_frame[i]) probe_frame[i] = 8'h00;
        send_packet(probe_frame, 2, 1'b0);
        probe_frame[FRAME_BYTES-1] = 8'h01;
        send_packet(probe_frame, FRAME_BYTES, 1'b0);
        drain();

        write_timeout(16'd3);
        random_run(PHASE_ITEMS);
        drain();

        write_timeout(16'd0);
        send_idle = 86;
        recv_idle <= 32;
        random_run(PHASE_ITEMS);
        drain();

        write_timeout(16'd20);
        send_idle = 0;
        recv_idle <= 0;
        hold_req  <= 1'b1;
        random_run(PHASE_ITEMS);
        drain();

        // top timeout setting with a frame well inside it
        write_timeout(16'hFFFF);
        send_event(ACT_TICK, 8'h00, 1'b1);
        send_random_frame(FRAME_BYTES, 1'b0);
        drain();

        $display("covered %0d input events (%0d in frames and ticks), %0d results checked",
                 events_sent, useful_sent, readings_seen);
        $display("%0d timeouts, %0d checksum errors, timeout register at 1000, 3, 0, 20, 65535",
                 timeouts_seen, crc_errors_seen);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
